// ===== rtl/rhh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhh_pkg: shared types and constants for the Robin Hood hash table
// Sizes of the table, slot record layout and request/status codes.
// ----------------------------------------------------------------------------
package rhh_pkg;

  localparam int MAX_SLOTS  = 1024;
  localparam int IDX_BITS   = $clog2(MAX_SLOTS);
  localparam int CNT_BITS   = IDX_BITS + 1;
  localparam int KEY_BITS   = 64;
  localparam int VALUE_BITS = 64;
  localparam int HASH_BITS  = 32;
  localparam int LOG2_BITS  = 4;
  localparam int LIMIT_BITS = 11;
  localparam int CFG_BITS   = 11;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SLOT_LOG2 = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PROBE_LIM = 1'b1;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_LIMIT     = 2'd2
  } status_t;

  // The used flag lives in the slot record, so one memory holds all state.
  typedef struct packed {
    logic                  used;
    logic [HASH_BITS-1:0]  hash;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } slot_t;

endpackage

// ===== rtl/robin_hood_hash_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// robin_hood_hash_table: Robin Hood open-addressing hash table
// Lookup, insert and backward-shift remove over a single slot memory.
// ----------------------------------------------------------------------------
// Usage notes.
// Requests enter on the in_ stream (tdata = kind, key_hash, key_word,
// entry_value). One result per request leaves on the out_ stream
// (tdata = status, read_value). The requester supplies the 32-bit hash; the
// home slot is the hash masked to 2^slot_count_log2 slots (a zero log2 counts as 1, above 10 as 10).
// Configuration is a plain write port: index 0 is slot_count_log2, index 1
// is probe_limit. Write only while the table is idle.
// Flow: the table serves one request at a time. Each examined slot takes a
// memory read, then a compare and optional write; this holds for every slot
// of an insert's displacement chain and every step of a remove's backward
// shift (the step that ends the shift counts too). An unused kind or a zero
// probe limit answers without reading the memory. in_tready rises again in
// the cycle after the result transfer.
// Reset: a clearing pass writes every slot empty, one per cycle, and
// in_tready stays low until the pass has cleared the last slot.
// When the receiver stalls, the finished result waits in the output
// register and the next request is held off until it is transferred.
// ----------------------------------------------------------------------------
module robin_hood_hash_table import rhh_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [1:0] kind, [33:2] key_hash, [97:34] key_word, [161:98] entry_value
  input  logic [167:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [1:0] status, [65:2] read_value
  output logic [71:0]  out_tdata,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_wdata
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_EVAL, S_SHREAD, S_SHEVAL, S_DONE
  } state_t;

  state_t state_r;

  logic [LOG2_BITS-1:0]  log2_r;
  logic [LIMIT_BITS-1:0] limit_r;

  // Request being served
  kind_t                 kind_r;
  slot_t                 cur_r;       // entry being placed (new or carried)
  logic [IDX_BITS-1:0]   idx_r;       // slot being probed
  logic [LIMIT_BITS-1:0] step_r;      // probe position within this leg
  logic [IDX_BITS:0]     dib_r;       // carried entry's distance at its base
  logic                  carry_r;     // in displacement chain
  logic [CNT_BITS-1:0]   chain_r;     // displacements made so far
  logic [IDX_BITS-1:0]   empty_r;     // hole during backward shift
  logic [IDX_BITS-1:0]   shcnt_r;
  logic [IDX_BITS-1:0]   clr_r;       // slot being cleared after reset

  status_t               status_r;
  logic [VALUE_BITS-1:0] rval_r;
  logic                  out_valid_r;

  // Slot memory, used flag included
  slot_t                 mem [MAX_SLOTS];
  slot_t                 rd_q;
  logic [IDX_BITS-1:0]   rd_addr;
  logic                  wr_en;
  logic [IDX_BITS-1:0]   wr_addr;
  slot_t                 wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Effective slot count as an index mask
  logic [LOG2_BITS-1:0] eff_log2;
  logic [IDX_BITS-1:0]  mask;
  always_comb begin
    eff_log2 = log2_r;
    if (eff_log2 == '0) eff_log2 = LOG2_BITS'(1);
    if (eff_log2 > LOG2_BITS'(IDX_BITS)) eff_log2 = LOG2_BITS'(IDX_BITS);
    mask = IDX_BITS'((CNT_BITS'(1) << eff_log2) - CNT_BITS'(1));
  end

  // Evaluation of the read slot
  logic                 slot_used;
  logic [IDX_BITS-1:0]  probe_gap;
  logic [IDX_BITS-1:0]  idx_next;
  logic [IDX_BITS-1:0]  idx_next_sh;
  logic                 match;
  logic [IDX_BITS+LIMIT_BITS:0] pos_now;   // cdib + i for chain, else i
  logic [LIMIT_BITS-1:0] step_inc;
  logic [LIMIT_BITS:0]  gap_ext;
  logic [LIMIT_BITS:0]  step_ext;
  logic                 take_slot;
  logic                 shift_go;
  always_comb begin
    slot_used   = rd_q.used;
    probe_gap   = (idx_r - rd_q.hash[IDX_BITS-1:0]) & mask;
    idx_next    = (idx_r + IDX_BITS'(1)) & mask;
    idx_next_sh = (empty_r + IDX_BITS'(1)) & mask;
    match       = (rd_q.hash == cur_r.hash) && (rd_q.key == cur_r.key);
    pos_now     = carry_r ? ((IDX_BITS+LIMIT_BITS+1)'(dib_r) +
                             (IDX_BITS+LIMIT_BITS+1)'(step_r))
                          : (IDX_BITS+LIMIT_BITS+1)'(step_r);
    step_inc    = step_r + LIMIT_BITS'(1);
    gap_ext     = (LIMIT_BITS+1)'(probe_gap);
    step_ext    = (LIMIT_BITS+1)'(step_r);
    // The resident entry is richer than the one being placed.
    take_slot   = (IDX_BITS+LIMIT_BITS+1)'(probe_gap) < pos_now;
    // The follower moves back unless it is absent, already home, or the
    // shift has covered the whole table.
    shift_go    = rd_q.used && ((rd_q.hash[IDX_BITS-1:0] & mask) != idx_next_sh) &&
                  (shcnt_r != mask);
  end

  assign rd_addr = (state_r == S_SHREAD || state_r == S_SHEVAL) ? idx_next_sh : idx_r;

  // A remove leaves its slot marked used until the shift ends; the last hole
  // of the shift is then written empty. Each cycle needs only one write.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = cur_r;
    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
      end
      S_EVAL: begin
        if (kind_r == KIND_INSERT && (!slot_used || take_slot)) wr_en = 1'b1;
      end
      S_SHEVAL: begin
        wr_en   = 1'b1;
        wr_addr = empty_r;
        wr_data = shift_go ? rd_q : '0;
      end
      default: wr_en = 1'b0;
    endcase
  end

  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, rval_r, status_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      log2_r      <= LOG2_BITS'(10);
      limit_r     <= LIMIT_BITS'(16);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SLOT_LOG2) log2_r <= cfg_wdata[LOG2_BITS-1:0];
        else if (cfg_index == CFG_PROBE_LIM) limit_r <= cfg_wdata[LIMIT_BITS-1:0];
      end
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + IDX_BITS'(1);
          if (clr_r == IDX_BITS'(MAX_SLOTS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            kind_r     <= kind_t'(in_tdata[1:0]);
            cur_r      <= {1'b1, in_tdata[33:2], in_tdata[97:34], in_tdata[161:98]};
            idx_r      <= in_tdata[2 +: IDX_BITS] & mask;
            step_r     <= '0;
            dib_r      <= '0;
            carry_r    <= 1'b0;
            chain_r    <= '0;
            rval_r     <= '0;
            if (in_tdata[1:0] == KIND_NONE) begin
              status_r <= ST_NOT_FOUND;
              state_r  <= S_DONE;
            end else if (limit_r == '0) begin
              status_r <= (in_tdata[1:0] == KIND_INSERT) ? ST_LIMIT : ST_NOT_FOUND;
              state_r  <= S_DONE;
            end else begin
              state_r  <= S_READ;
            end
          end
        end
        S_READ: state_r <= S_EVAL;
        S_EVAL: begin
          case (kind_r)
            KIND_LOOKUP: begin
              if (!slot_used || gap_ext < step_ext) begin
                status_r <= ST_NOT_FOUND;
                state_r  <= S_DONE;
              end else if (match) begin
                status_r <= ST_OK;
                rval_r   <= rd_q.value;
                state_r  <= S_DONE;
              end else if (step_inc == limit_r) begin
                status_r <= ST_LIMIT;
                state_r  <= S_DONE;
              end else begin
                idx_r    <= idx_next;
                step_r   <= step_inc;
                state_r  <= S_READ;
              end
            end
            KIND_REMOVE: begin
              if (!slot_used) begin
                status_r <= ST_NOT_FOUND;
                state_r  <= S_DONE;
              end else if (match) begin
                empty_r  <= idx_r;
                shcnt_r  <= '0;
                status_r <= ST_OK;
                state_r  <= S_SHREAD;
              end else if (gap_ext < step_ext) begin
                status_r <= ST_NOT_FOUND;
                state_r  <= S_DONE;
              end else if (step_inc == limit_r) begin
                status_r <= ST_LIMIT;
                state_r  <= S_DONE;
              end else begin
                idx_r    <= idx_next;
                step_r   <= step_inc;
                state_r  <= S_READ;
              end
            end
            KIND_INSERT: begin
              if (!slot_used) begin
                status_r <= ST_OK;
                state_r  <= S_DONE;
              end else if (take_slot) begin
                // Take the richer slot; carry its entry onward.
                cur_r   <= rd_q;
                dib_r   <= (IDX_BITS+1)'(probe_gap);
                carry_r <= 1'b1;
                chain_r <= chain_r + CNT_BITS'(1);
                idx_r   <= idx_next;
                step_r  <= LIMIT_BITS'(1);
                if (carry_r && chain_r == CNT_BITS'(MAX_SLOTS)) begin
                  status_r <= ST_LIMIT;
                  state_r  <= S_DONE;
                end else begin
                  state_r  <= S_READ;
                end
              end else if ((carry_r ? step_r : step_inc) == limit_r) begin
                status_r <= ST_LIMIT;
                state_r  <= S_DONE;
              end else begin
                idx_r    <= idx_next;
                step_r   <= step_inc;
                state_r  <= S_READ;
              end
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_SHREAD: state_r <= S_SHEVAL;
        S_SHEVAL: begin
          if (shift_go) begin
            empty_r <= idx_next_sh;
            shcnt_r <= shcnt_r + IDX_BITS'(1);
            state_r <= S_SHREAD;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == S_IDLE)) else $error("ready while busy");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (status_r == ST_OK || status_r == ST_NOT_FOUND ||
                    status_r == ST_LIMIT)) else $error("bad status");
  a_rval_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && status_r != ST_OK) |-> (rval_r == '0)) else $error("stray value");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the Robin Hood hash table
// Drives lookup, insert and remove requests with random gaps and stalls. It
// predicts every status and read value from its own copy of the table and
// moves through several table sizes and probe limits.
// ----------------------------------------------------------------------------

import rhh_pkg::*;

// Scoreboard: a shadow copy of the slot store that predicts each result.
class hash_table_scoreboard;

  bit                    used_q [MAX_SLOTS];
  logic [HASH_BITS-1:0]  hash_q [MAX_SLOTS];
  logic [KEY_BITS-1:0]   key_q  [MAX_SLOTS];
  logic [VALUE_BITS-1:0] val_q  [MAX_SLOTS];
  int unsigned           log2_reg;
  int unsigned           limit_reg;

  status_t               want_status [$];
  logic [VALUE_BITS-1:0] want_value  [$];

  int mismatches;
  int results_seen;
  int kind_count [4];
  int ok_count;

  function void clear();
    foreach (used_q[i]) used_q[i] = 1'b0;
    log2_reg  = 10;
    limit_reg = 16;
  endfunction

  function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
    if (idx == CFG_SLOT_LOG2) log2_reg = data[LOG2_BITS-1:0];
    else if (idx == CFG_PROBE_LIM) limit_reg = data[LIMIT_BITS-1:0];
  endfunction

  function int pending();
    return want_status.size();
  endfunction

  function int unsigned slot_total();
    int unsigned l;
    l = (log2_reg < 1) ? 1 : log2_reg;
    if (l > 16) l = 16;
    return ((1 << l) > MAX_SLOTS) ? MAX_SLOTS : (1 << l);
  endfunction

  // How far an occupied slot sits from its home slot.
  function int unsigned home_gap(int unsigned idx, int unsigned n);
    return (idx + n - (hash_q[idx] % n)) % n;
  endfunction

  function void fill(int unsigned idx, logic [HASH_BITS-1:0] h,
                     logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v);
    used_q[idx] = 1'b1;
    hash_q[idx] = h;
    key_q[idx]  = k;
    val_q[idx]  = v;
  endfunction

  function status_t place(logic [HASH_BITS-1:0] h, logic [KEY_BITS-1:0] k,
                          logic [VALUE_BITS-1:0] v, int unsigned n);
    int unsigned           cidx, cdist, idx, t;
    logic [HASH_BITS-1:0]  ch, th;
    logic [KEY_BITS-1:0]   ck, tk;
    logic [VALUE_BITS-1:0] cv, tv;
    bit                    carried, moved;
    carried = 1'b0;
    for (int unsigned i = 0; i < limit_reg; i++) begin
      idx = ((h % n) + i) % n;
      if (!used_q[idx]) begin
        fill(idx, h, k, v);
        return ST_OK;
      end
      if (home_gap(idx, n) < i) begin
        ch = hash_q[idx]; ck = key_q[idx]; cv = val_q[idx];
        cdist = home_gap(idx, n);
        cidx = idx;
        fill(idx, h, k, v);
        carried = 1'b1;
        break;
      end
    end
    if (!carried) return ST_LIMIT;
    // Carry the displaced entry on until it lands; it is lost if it cannot.
    for (int steps = 0; steps < MAX_SLOTS; steps++) begin
      moved = 1'b0;
      for (int unsigned i = 1; i <= limit_reg; i++) begin
        t = (cidx + i) % n;
        if (!used_q[t]) begin
          fill(t, ch, ck, cv);
          return ST_OK;
        end
        if (home_gap(t, n) < cdist + i) begin
          th = hash_q[t]; tk = key_q[t]; tv = val_q[t];
          cdist = home_gap(t, n);
          fill(t, ch, ck, cv);
          ch = th; ck = tk; cv = tv;
          cidx = t;
          moved = 1'b1;
          break;
        end
      end
      if (!moved) return ST_LIMIT;
    end
    return ST_LIMIT;
  endfunction

  // Backward-shift deletion: pull followers into the hole until one is home.
  function void close_gap(int unsigned hole, int unsigned n);
    int unsigned nx;
    for (int unsigned i = 1; i < n; i++) begin
      nx = (hole + 1) % n;
      if (!used_q[nx] || (hash_q[nx] % n) == nx) return;
      fill(hole, hash_q[nx], key_q[nx], val_q[nx]);
      used_q[nx] = 1'b0;
      hole = nx;
    end
  endfunction

  function void note_request(kind_t kind, logic [HASH_BITS-1:0] h,
                             logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v);
    int unsigned           n, idx;
    status_t               st;
    logic [VALUE_BITS-1:0] rv;
    n  = slot_total();
    st = ST_NOT_FOUND;
    rv = '0;
    kind_count[kind]++;
    case (kind)
      KIND_LOOKUP: begin
        st = (limit_reg == 0) ? ST_NOT_FOUND : ST_LIMIT;
        for (int unsigned i = 0; i < limit_reg; i++) begin
          idx = ((h % n) + i) % n;
          if (!used_q[idx] || home_gap(idx, n) < i) begin
            st = ST_NOT_FOUND;
            break;
          end
          if (hash_q[idx] == h && key_q[idx] == k) begin
            st = ST_OK;
            rv = val_q[idx];
            break;
          end
        end
      end
      KIND_INSERT: st = place(h, k, v, n);
      KIND_REMOVE: begin
        st = (limit_reg == 0) ? ST_NOT_FOUND : ST_LIMIT;
        for (int unsigned i = 0; i < limit_reg; i++) begin
          idx = ((h % n) + i) % n;
          if (!used_q[idx]) begin
            st = ST_NOT_FOUND;
            break;
          end
          if (hash_q[idx] == h && key_q[idx] == k) begin
            used_q[idx] = 1'b0;
            close_gap(idx, n);
            st = ST_OK;
            break;
          end
          if (home_gap(idx, n) < i) begin
            st = ST_NOT_FOUND;
            break;
          end
        end
      end
      default: st = ST_NOT_FOUND;
    endcase
    if (st == ST_OK) ok_count++;
    want_status.push_back(st);
    want_value.push_back(rv);
  endfunction

  function void check_result(logic [1:0] st, logic [VALUE_BITS-1:0] rv);
    status_t               es;
    logic [VALUE_BITS-1:0] ev;
    results_seen++;
    if (want_status.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d arrived with nothing expected: status %0d value %h",
                 results_seen, st, rv);
      return;
    end
    es = want_status.pop_front();
    ev = want_value.pop_front();
    if (st !== es || rv !== ev) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: status %0d value %h, expected status %0d value %h",
                 results_seen, st, rv, es, ev);
    end
  endfunction
endclass

module tb;
  import rhh_pkg::*;

  // Well above the longest request a full displacement chain can take.
  localparam int WATCHDOG_LIMIT = 5000000;

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  // [1:0] kind, [33:2] key_hash, [97:34] key_word, [161:98] entry_value
  logic [167:0]            in_tdata;
  logic                    out_tvalid;
  logic                    out_tready;
  // [1:0] status, [65:2] read_value
  logic [71:0]             out_tdata;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]     cfg_wdata;

  hash_table_scoreboard sb;

  // When set, neither side inserts gaps or stalls.
  bit steady;
  int idle_cycles;
  int settings_used;

  // Pool of keys for the current phase, so that lookups and removes hit.
  logic [HASH_BITS-1:0] pool_hash [12];
  logic [KEY_BITS-1:0]  pool_key  [12];

  robin_hood_hash_table DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // The receiver stalls about a third of the time unless the bench is steady.
  always @(negedge clk) begin
    out_tready <= steady ? 1'b1 : ($urandom_range(99) >= 35);
  end

  // Monitor: every transfer on either side is seen here, before the flops
  // of the block update. An input transfer feeds the scoreboard's predictor
  // and an output transfer is checked against the oldest prediction. The
  // watchdog ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_request(kind_t'(in_tdata[1:0]), in_tdata[33:2], in_tdata[97:34],
                        in_tdata[161:98]);
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata[1:0], out_tdata[65:2]);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no transfer for %0d cycles", idle_cycles);
          $display("tb: errors");
          $finish;
        end
      end
    end
  end

  // Offers one request and returns at the falling edge after its transfer.
  // Called at a falling edge.
  task automatic send(kind_t kind, logic [HASH_BITS-1:0] h,
                      logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v);
    if (!steady) begin
      while ($urandom_range(99) < 35) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, v, k, h, kind};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Drops the request side, lets every result come back and then lets the
  // block settle before the next configuration write or the end of the run.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Register writes happen only while the table is idle.
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_table(int unsigned log2_val, int unsigned limit_val);
    write_reg(CFG_SLOT_LOG2, CFG_BITS'(log2_val));
    write_reg(CFG_PROBE_LIM, CFG_BITS'(limit_val));
    settings_used++;
  endtask

  // New pool for a phase. The low hash bits are squeezed into a few values
  // so that small tables see crowded clusters and long probe runs.
  task automatic refill_pool();
    for (int i = 0; i < 12; i++) begin
      pool_hash[i]      = $urandom;
      pool_hash[i][3:0] = 4'($urandom_range(3));
      pool_key[i]       = {$urandom, $urandom};
    end
  endtask

  // Mostly well-formed traffic on pooled keys, with fresh keys, unused kinds
  // and mismatched hash/key pairs mixed in as noise.
  task automatic random_phase(int count);
    int                    p, roll;
    kind_t                 kind;
    logic [HASH_BITS-1:0]  h;
    logic [KEY_BITS-1:0]   k;
    refill_pool();
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 40) kind = KIND_INSERT;
      else if (roll < 70) kind = KIND_LOOKUP;
      else if (roll < 95) kind = KIND_REMOVE;
      else kind = KIND_NONE;
      p = $urandom_range(11);
      h = pool_hash[p];
      k = pool_key[p];
      roll = $urandom_range(99);
      if (roll < 12) begin
        h = $urandom;
        k = {$urandom, $urandom};
      end else if (roll < 17) begin
        k = pool_key[$urandom_range(11)];
      end
      send(kind, h, k, {$urandom, $urandom});
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    steady     = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    idle_cycles   = 0;
    settings_used = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at the reset settings: an empty lookup, field extremes,
    // a hit, a duplicate insert, removes that hit and miss, the unused kind.
    send(KIND_LOOKUP, 32'h0, 64'h0, 64'h0);
    send(KIND_INSERT, 32'h0, 64'h0, '1);
    send(KIND_INSERT, '1, '1, 64'h0);
    send(KIND_INSERT, 32'h0000_0400, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send(KIND_LOOKUP, 32'h0000_0400, 64'h5555_5555_5555_5555, '1);
    send(KIND_LOOKUP, '1, '1, 64'h0);
    send(KIND_INSERT, '1, '1, 64'h1234);
    send(KIND_REMOVE, 32'h0, 64'h0, 64'h0);
    send(KIND_LOOKUP, 32'h0000_0400, 64'h5555_5555_5555_5555, 64'h0);
    send(KIND_REMOVE, 32'h0, 64'h1, 64'h0);
    send(KIND_NONE, '1, '1, '1);

    // A zero probe limit answers without touching the table.
    set_table(10, 0);
    send(KIND_LOOKUP, '1, '1, 64'h0);
    send(KIND_INSERT, 32'h7, 64'h7, 64'h7);
    send(KIND_REMOVE, '1, '1, 64'h0);

    // Two slots and a limit of one: the second entry for a home runs out.
    set_table(1, 1);
    send(KIND_INSERT, 32'h2, 64'h21, 64'h1);
    send(KIND_INSERT, 32'h4, 64'h22, 64'h2);
    send(KIND_LOOKUP, 32'h6, 64'h23, 64'h0);
    send(KIND_REMOVE, 32'h8, 64'h24, 64'h0);

    // A slot count field of zero counts as two slots; a displaced entry that
    // finds no slot within the limit is dropped while the new entry stays.
    set_table(0, 2);
    send(KIND_INSERT, 32'h1, 64'h31, 64'h3);
    send(KIND_INSERT, 32'h3, 64'h32, 64'h4);
    send(KIND_LOOKUP, 32'h3, 64'h32, 64'h0);
    send(KIND_LOOKUP, 32'h2, 64'h21, 64'h0);

    // Random phases through several settings, the extremes among them. The
    // table keeps its entries across size changes.
    set_table(2, 3);      random_phase(70);
    set_table(3, 1024);   random_phase(70);
    steady = 1'b1;
    set_table(4, 2047);   random_phase(70);
    steady = 1'b0;
    set_table(15, 16);    random_phase(70);
    set_table(1, 4);      random_phase(60);
    set_table(5, 6);      random_phase(80);
    set_table(10, 1024);  random_phase(60);

    drain();
    repeat (20) @(negedge clk);
    $display("covered %0d lookups, %0d inserts, %0d removes, %0d unused kinds",
             sb.kind_count[KIND_LOOKUP], sb.kind_count[KIND_INSERT],
             sb.kind_count[KIND_REMOVE], sb.kind_count[KIND_NONE]);
    $display("%0d results checked, %0d successes, %0d table settings, %0d mismatches",
             sb.results_seen, sb.ok_count, settings_used, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
